// ===== rtl/uctb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package uctb_pkg;

    localparam int unsigned CAPACITY_DEF = 2048;

    localparam int unsigned OP_W   = 3;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned LEN_W  = 12;
    localparam int unsigned IDX_W  = 11;
    localparam int unsigned POS_W  = 12;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 3'd0,
        OP_DELETE = 3'd1,
        OP_LEFT   = 3'd2,
        OP_RIGHT  = 3'd3,
        OP_CLEAR  = 3'd4,
        OP_READ   = 3'd5
    } op_t;

    localparam logic [BYTE_W-1:0] CONT_MASK = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_TAG  = 8'h80;

    function automatic logic is_cont(input logic [BYTE_W-1:0] b);
        return (b & CONT_MASK) == CONT_TAG;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/uctb_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface uctb_in_if import uctb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] data_byte;
    logic              commit_first;
    logic [LEN_W-1:0]  commit_length;
    logic [IDX_W-1:0]  read_index;

    modport source (
        output valid, op, data_byte, commit_first, commit_length, read_index,
        input  ready
    );

    modport sink (
        input  valid, op, data_byte, commit_first, commit_length, read_index,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/uctb_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface uctb_out_if import uctb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] read_byte;
    logic [POS_W-1:0]  text_length;
    logic [POS_W-1:0]  cursor_position;
    logic              accepted;

    modport source (
        output valid, read_byte, text_length, cursor_position, accepted,
        input  ready
    );

    modport sink (
        input  valid, read_byte, text_length, cursor_position, accepted,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/utf8_cursor_text_buffer.sv =====
// utf8_cursor_text_buffer: bounded utf-8 edit buffer with a byte cursor.
// cmd takes one word per edit (insert, delete, left, right, clear, read);
// rsp returns exactly one word per cmd word: read byte, text length,
// cursor position and the insert accepted flag.
// one item is handled at a time. the text lives in a single memory with
// one read and one write port and a registered read; every shift of the
// text moves one byte per cycle through that port pair.
// an insert shifts the bytes after the cursor up through that port pair
// and writes the new byte at the cursor; a delete scans back to the
// codepoint start and shifts the tail down; left and right scan over
// continuation bytes. the first byte of a commit that overflows first
// drops the oldest text, keeping the newest CAPACITY/2 bytes, and backs
// the cursor over continuation bytes.
// cmd.ready is high only while no item is in work; a finished word waits
// in the rsp register, so one more item is taken while rsp is stalled,
// and that item holds before its result until the register is free.
// reset (rst_n low, asynchronous) empties the text, sets the cursor and
// the commit budget to zero and drops any pending rsp word.
`timescale 1ns / 1ps
`default_nettype none

module utf8_cursor_text_buffer import uctb_pkg::*; #(
    parameter int unsigned CAPACITY = CAPACITY_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    uctb_in_if.sink    cmd,
    uctb_out_if.source rsp
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned SW = ((CW > LEN_W) ? CW : LEN_W) + 1;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] KEEP  = CW'(CAPACITY / 2);

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_DECODE = 14'b00000000000010,
        S_BUDGET = 14'b00000000000100,
        S_INS    = 14'b00000000001000,
        S_COPY   = 14'b00000000010000,
        S_PUT    = 14'b00000000100000,
        S_LSCAN  = 14'b00000001000000,
        S_LWAIT  = 14'b00000010000000,
        S_RSCAN  = 14'b00000100000000,
        S_RWAIT  = 14'b00001000000000,
        S_BSCAN  = 14'b00010000000000,
        S_BWAIT  = 14'b00100000000000,
        S_RDWAIT = 14'b01000000000000,
        S_OUT    = 14'b10000000000000
    } state_t;

    typedef enum logic [1:0] {
        RET_DROP = 2'd0,
        RET_PUT  = 2'd1,
        RET_DEL  = 2'd2
    } ret_t;

    logic [BYTE_W-1:0] mem [CAPACITY];
    logic [BYTE_W-1:0] rd_data_reg;
    logic              mem_re;
    logic [AW-1:0]     mem_ra;
    logic              mem_we;
    logic [AW-1:0]     mem_wa;
    logic [BYTE_W-1:0] mem_wd;

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     cursor_reg, cursor_next;
    logic [CW-1:0]     budget_reg, budget_next;
    logic              pend_reg, pend_next;
    logic              out_valid_reg, out_valid_next;

    logic [OP_W-1:0]   op_reg, op_next;
    logic [BYTE_W-1:0] data_reg, data_next;
    logic              first_reg, first_next;
    logic [LEN_W-1:0]  clen_reg, clen_next;
    logic [IDX_W-1:0]  ridx_reg, ridx_next;
    logic [CW-1:0]     scan_reg, scan_next;
    logic [AW-1:0]     src_reg, src_next;
    logic [AW-1:0]     dst_reg, dst_next;
    logic [CW-1:0]     left_reg, left_next;
    logic              down_reg, down_next;
    ret_t              ret_reg, ret_next;
    logic [BYTE_W-1:0] rbyte_reg, rbyte_next;
    logic              acc_reg, acc_next;
    logic [BYTE_W-1:0] o_byte_reg, o_byte_next;
    logic [POS_W-1:0]  o_len_reg, o_len_next;
    logic [POS_W-1:0]  o_cur_reg, o_cur_next;
    logic              o_acc_reg, o_acc_next;

    logic [SW-1:0]     fit_sum;
    logic [CW-1:0]     drop;
    logic [CW-1:0]     ins_cur;
    logic              ldone;
    logic [CW-1:0]     lpos;

    assign cmd.ready           = (state_reg == S_IDLE);
    assign rsp.valid           = out_valid_reg;
    assign rsp.read_byte       = o_byte_reg;
    assign rsp.text_length     = o_len_reg;
    assign rsp.cursor_position = o_cur_reg;
    assign rsp.accepted        = o_acc_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        cursor_next    = cursor_reg;
        budget_next    = budget_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        op_next        = op_reg;
        data_next      = data_reg;
        first_next     = first_reg;
        clen_next      = clen_reg;
        ridx_next      = ridx_reg;
        scan_next      = scan_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        left_next      = left_reg;
        down_next      = down_reg;
        ret_next       = ret_reg;
        rbyte_next     = rbyte_reg;
        acc_next       = acc_reg;
        o_byte_next    = o_byte_reg;
        o_len_next     = o_len_reg;
        o_cur_next     = o_cur_reg;
        o_acc_next     = o_acc_reg;
        mem_re         = 1'b0;
        mem_ra         = '0;
        mem_we         = 1'b0;
        mem_wa         = '0;
        mem_wd         = '0;
        fit_sum        = SW'(count_reg) + SW'(clen_reg);
        drop           = count_reg - KEEP;
        ins_cur        = (cursor_reg > count_reg) ? count_reg : cursor_reg;
        ldone          = 1'b0;
        lpos           = scan_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    op_next    = cmd.op;
                    data_next  = cmd.data_byte;
                    first_next = cmd.commit_first;
                    clen_next  = cmd.commit_length;
                    ridx_next  = cmd.read_index;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                rbyte_next = '0;
                acc_next   = 1'b0;
                state_next = S_OUT;
                case (op_reg)
                    OP_INSERT:
                    begin
                        if (!first_reg)
                        begin
                            state_next = S_INS;
                        end
                        else if (clen_reg == '0)
                        begin
                            budget_next = '0;
                            state_next  = S_INS;
                        end
                        else if ((fit_sum > SW'(CAPACITY)) && (count_reg > KEEP))
                        begin
                            cursor_next = (cursor_reg > drop) ? cursor_reg - drop : '0;
                            count_next  = KEEP;
                            src_next    = AW'(drop);
                            dst_next    = '0;
                            left_next   = KEEP;
                            down_next   = 1'b0;
                            ret_next    = RET_DROP;
                            pend_next   = 1'b0;
                            state_next  = S_COPY;
                        end
                        else
                        begin
                            state_next = S_BUDGET;
                        end
                    end
                    OP_DELETE, OP_LEFT:
                    begin
                        if (cursor_reg != '0)
                        begin
                            scan_next  = cursor_reg - 1'b1;
                            state_next = S_LSCAN;
                        end
                    end
                    OP_RIGHT:
                    begin
                        if (cursor_reg >= count_reg)
                        begin
                            cursor_next = count_reg;
                        end
                        else
                        begin
                            scan_next  = cursor_reg + 1'b1;
                            state_next = S_RSCAN;
                        end
                    end
                    OP_CLEAR:
                    begin
                        count_next  = '0;
                        cursor_next = '0;
                        budget_next = '0;
                    end
                    OP_READ:
                    begin
                        if (SW'(ridx_reg) < SW'(count_reg))
                        begin
                            mem_re     = 1'b1;
                            mem_ra     = AW'(ridx_reg);
                            state_next = S_RDWAIT;
                        end
                    end
                    default:
                    begin
                        state_next = S_OUT;
                    end
                endcase
            end

            S_BUDGET:
            begin
                if (fit_sum <= SW'(CAPACITY))
                begin
                    budget_next = CW'(clen_reg);
                end
                else
                begin
                    budget_next = CAP_C - count_reg;
                end
                state_next = S_INS;
            end

            S_INS:
            begin
                if ((budget_reg == '0) || (count_reg >= CAP_C))
                begin
                    acc_next   = 1'b0;
                    state_next = S_OUT;
                end
                else
                begin
                    cursor_next = ins_cur;
                    src_next    = AW'(count_reg - 1'b1);
                    dst_next    = AW'(count_reg);
                    left_next   = count_reg - ins_cur;
                    down_next   = 1'b1;
                    ret_next    = RET_PUT;
                    pend_next   = 1'b0;
                    state_next  = S_COPY;
                end
            end

            S_COPY:
            begin
                if (pend_reg)
                begin
                    mem_we   = 1'b1;
                    mem_wa   = dst_reg;
                    mem_wd   = rd_data_reg;
                    dst_next = down_reg ? dst_reg - 1'b1 : dst_reg + 1'b1;
                end
                if (left_reg != '0)
                begin
                    mem_re    = 1'b1;
                    mem_ra    = src_reg;
                    src_next  = down_reg ? src_reg - 1'b1 : src_reg + 1'b1;
                    left_next = left_reg - 1'b1;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        case (ret_reg)
                            RET_DROP:
                            begin
                                state_next = S_BSCAN;
                            end
                            RET_PUT:
                            begin
                                state_next = S_PUT;
                            end
                            default:
                            begin
                                count_next  = count_reg - (cursor_reg - scan_reg);
                                cursor_next = scan_reg;
                                state_next  = S_OUT;
                            end
                        endcase
                    end
                end
            end

            S_PUT:
            begin
                mem_we      = 1'b1;
                mem_wa      = AW'(cursor_reg);
                mem_wd      = data_reg;
                count_next  = count_reg + 1'b1;
                cursor_next = cursor_reg + 1'b1;
                budget_next = budget_reg - 1'b1;
                acc_next    = 1'b1;
                state_next  = S_OUT;
            end

            S_LSCAN:
            begin
                if ((scan_reg == '0) || (scan_reg >= count_reg))
                begin
                    ldone = 1'b1;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_ra     = AW'(scan_reg);
                    state_next = S_LWAIT;
                end
            end

            S_LWAIT:
            begin
                if (is_cont(rd_data_reg))
                begin
                    scan_next  = scan_reg - 1'b1;
                    state_next = S_LSCAN;
                end
                else
                begin
                    ldone = 1'b1;
                end
            end

            S_RSCAN:
            begin
                if (scan_reg >= count_reg)
                begin
                    cursor_next = count_reg;
                    state_next  = S_OUT;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_ra     = AW'(scan_reg);
                    state_next = S_RWAIT;
                end
            end

            S_RWAIT:
            begin
                if (is_cont(rd_data_reg))
                begin
                    scan_next  = scan_reg + 1'b1;
                    state_next = S_RSCAN;
                end
                else
                begin
                    cursor_next = scan_reg;
                    state_next  = S_OUT;
                end
            end

            S_BSCAN:
            begin
                if ((cursor_reg == '0) || (cursor_reg >= count_reg))
                begin
                    state_next = S_BUDGET;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_ra     = AW'(cursor_reg);
                    state_next = S_BWAIT;
                end
            end

            S_BWAIT:
            begin
                if (is_cont(rd_data_reg))
                begin
                    cursor_next = cursor_reg - 1'b1;
                    state_next  = S_BSCAN;
                end
                else
                begin
                    state_next = S_BUDGET;
                end
            end

            S_RDWAIT:
            begin
                rbyte_next = rd_data_reg;
                state_next = S_OUT;
            end

            S_OUT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    o_byte_next    = rbyte_reg;
                    o_len_next     = POS_W'(count_reg);
                    o_cur_next     = POS_W'(cursor_reg);
                    o_acc_next     = acc_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // codepoint start before the cursor found
        if (ldone)
        begin
            if (op_reg == OP_LEFT)
            begin
                cursor_next = lpos;
                state_next  = S_OUT;
            end
            else
            begin
                scan_next  = lpos;
                src_next   = AW'(cursor_reg);
                dst_next   = AW'(lpos);
                left_next  = count_reg - cursor_reg;
                down_next  = 1'b0;
                ret_next   = RET_DEL;
                pend_next  = 1'b0;
                state_next = S_COPY;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cursor_reg    <= '0;
            budget_reg    <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cursor_reg    <= cursor_next;
            budget_reg    <= budget_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        data_reg   <= data_next;
        first_reg  <= first_next;
        clen_reg   <= clen_next;
        ridx_reg   <= ridx_next;
        scan_reg   <= scan_next;
        src_reg    <= src_next;
        dst_reg    <= dst_next;
        left_reg   <= left_next;
        down_reg   <= down_next;
        ret_reg    <= ret_next;
        rbyte_reg  <= rbyte_next;
        acc_reg    <= acc_next;
        o_byte_reg <= o_byte_next;
        o_len_reg  <= o_len_next;
        o_cur_reg  <= o_cur_next;
        o_acc_reg  <= o_acc_next;
    end

endmodule

`default_nettype wire

// ===== tb/utf8_edit_checker.sv =====
`timescale 1ns / 1ps

module utf8_edit_checker import uctb_pkg::*; #(
    parameter int unsigned CAPACITY = CAPACITY_DEF
) (
    input  logic clk,
    input  logic rst_n,
    uctb_in_if   cmd_mon,
    uctb_out_if  rsp_mon,
    output int   fail_count,
    output int   pending_count
);

    localparam int KEEP = CAPACITY / 2;

    typedef struct packed {
        logic [BYTE_W-1:0] read_byte;
        logic [POS_W-1:0]  text_length;
        logic [POS_W-1:0]  cursor_position;
        logic              accepted;
    } edit_result_t;

    logic [BYTE_W-1:0] text_mem [CAPACITY];
    int                held_len    = 0;
    int                cursor_pos  = 0;
    int                commit_left = 0;

    edit_result_t      pending_results [$];
    edit_result_t      want;
    int                mismatches  = 0;
    int                outstanding = 0;

    assign fail_count    = mismatches;
    assign pending_count = outstanding;

    initial
    begin
        foreach (text_mem[i]) text_mem[i] = '0;
    end

    function automatic bit cont_at(input int pos);
        return pos < held_len && (text_mem[pos] & CONT_MASK) == CONT_TAG;
    endfunction

    function automatic int prev_start(input int pos);
        if (pos == 0) return 0;
        pos--;
        while (pos > 0 && cont_at(pos)) pos--;
        return pos;
    endfunction

    function automatic int next_start(input int pos);
        if (pos >= held_len) return held_len;
        pos++;
        while (pos < held_len && cont_at(pos)) pos++;
        return pos;
    endfunction

    function automatic edit_result_t predict_edit(
        input logic [OP_W-1:0]   code,
        input logic [BYTE_W-1:0] b,
        input logic              first,
        input logic [LEN_W-1:0]  clen,
        input logic [IDX_W-1:0]  ridx
    );
        edit_result_t r;
        int           i;
        int           need;
        int           drop;
        int           p;
        int           gap;
        r = '0;
        case (code)
            OP_INSERT:
            begin
                if (first) begin
                    need = int'(clen);
                    if (need == 0) begin
                        commit_left = 0;
                    end
                    else
                    begin
                        // make room by keeping only the newest half
                        if (held_len + need > CAPACITY && held_len > KEEP) begin
                            drop = held_len - KEEP;
                            for (i = 0; i < KEEP; i++) text_mem[i] = text_mem[i + drop];
                            held_len   = KEEP;
                            cursor_pos = (cursor_pos > drop) ? cursor_pos - drop : 0;
                            while (cursor_pos > 0 && cont_at(cursor_pos)) cursor_pos--;
                        end
                        commit_left = (held_len + need <= CAPACITY) ? need
                                                                    : CAPACITY - held_len;
                    end
                end
                if (commit_left != 0 && held_len < CAPACITY) begin
                    if (cursor_pos > held_len) cursor_pos = held_len;
                    for (i = held_len; i > cursor_pos; i--) text_mem[i] = text_mem[i - 1];
                    text_mem[cursor_pos] = b;
                    held_len++;
                    cursor_pos++;
                    commit_left--;
                    r.accepted = 1'b1;
                end
            end
            OP_DELETE:
            begin
                if (cursor_pos != 0) begin
                    p   = prev_start(cursor_pos);
                    gap = cursor_pos - p;
                    for (i = cursor_pos; i < held_len; i++) text_mem[i - gap] = text_mem[i];
                    held_len  -= gap;
                    cursor_pos = p;
                end
            end
            OP_LEFT:  cursor_pos = prev_start(cursor_pos);
            OP_RIGHT: cursor_pos = next_start(cursor_pos);
            OP_CLEAR:
            begin
                held_len    = 0;
                cursor_pos  = 0;
                commit_left = 0;
            end
            OP_READ:
            begin
                if (int'(ridx) < held_len) r.read_byte = text_mem[ridx];
            end
            default: ;
        endcase
        r.text_length     = POS_W'(held_len);
        r.cursor_position = POS_W'(cursor_pos);
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_val,
                                        input logic [31:0] got_val);
        if (got_val !== exp_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, got_val);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (rsp_mon.valid && rsp_mon.ready) begin
                if (pending_results.size() == 0) begin
                    $error("result word with no edit outstanding");
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("read_byte", 32'(want.read_byte), 32'(rsp_mon.read_byte));
                    check_field("text_length", 32'(want.text_length),
                                32'(rsp_mon.text_length));
                    check_field("cursor_position", 32'(want.cursor_position),
                                32'(rsp_mon.cursor_position));
                    check_field("accepted", 32'(want.accepted), 32'(rsp_mon.accepted));
                end
            end
            if (cmd_mon.valid && cmd_mon.ready)
                pending_results.push_back(predict_edit(cmd_mon.op, cmd_mon.data_byte,
                                                       cmd_mon.commit_first,
                                                       cmd_mon.commit_length,
                                                       cmd_mon.read_index));
            outstanding = pending_results.size();
        end
    end

endmodule

// ===== tb/tb_utf8_cursor_text_buffer.sv =====
`timescale 1ns / 1ps

module tb_utf8_cursor_text_buffer import uctb_pkg::*; ();

    localparam int                CLK_PERIOD = 10;
    localparam int                CAPACITY   = CAPACITY_DEF;
    localparam int                IDLE_MAX   = 17;
    localparam logic [OP_W-1:0]   OP_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0]   OP_SPARE_B = 3'd7;

    logic clk = 1'b0;
    logic rst_n;
    int   idle_max = IDLE_MAX;
    int   fail_count;
    int   pending;

    uctb_in_if  cmd_if ();
    uctb_out_if rsp_if ();

    utf8_cursor_text_buffer #(
        .CAPACITY (CAPACITY)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .rsp   (rsp_if)
    );

    utf8_edit_checker #(
        .CAPACITY (CAPACITY)
    ) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_mon       (cmd_if),
        .rsp_mon       (rsp_if),
        .fail_count    (fail_count),
        .pending_count (pending)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    initial
    begin
        #20ms;
        $display("FAIL");
        $finish;
    end

    // result side back-pressure
    initial
    begin
        int gap;
        forever
        begin
            gap = $urandom_range(0, idle_max);
            if (gap != 0) begin
                rsp_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_if.valid) @(posedge clk);
        end
    end

    task automatic send_word(
        input logic [OP_W-1:0]   op,
        input logic [BYTE_W-1:0] data,
        input logic              first,
        input logic [LEN_W-1:0]  clen,
        input logic [IDX_W-1:0]  ridx
    );
        int gap;
        if ($urandom_range(0, 23) == 0)
            idle_max = ($urandom_range(0, 2) == 0) ? 0 : IDLE_MAX;
        gap = $urandom_range(0, idle_max);
        if (gap != 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_if.valid         <= 1'b1;
        cmd_if.op            <= op;
        cmd_if.data_byte     <= data;
        cmd_if.commit_first  <= first;
        cmd_if.commit_length <= clen;
        cmd_if.read_index    <= ridx;
        @(posedge clk);
        while (!cmd_if.ready) @(posedge clk);
    endtask

    task automatic send_edit(input logic [OP_W-1:0] op);
        send_word(op, BYTE_W'($urandom), 1'($urandom), LEN_W'($urandom), IDX_W'($urandom));
    endtask

    task automatic send_insert(input logic [BYTE_W-1:0] data, input logic first,
                               input int clen);
        send_word(OP_INSERT, data, first, LEN_W'(clen), IDX_W'($urandom));
    endtask

    task automatic send_commit(ref logic [BYTE_W-1:0] bytes[$], input int clen);
        foreach (bytes[i]) send_insert(bytes[i], i == 0, clen);
    endtask

    function automatic void append_codepoint(input int nbytes, ref logic [BYTE_W-1:0] q[$]);
        logic [BYTE_W-1:0] lead;
        case (nbytes)
            1:       lead = BYTE_W'($urandom_range(0, 127));
            2:       lead = 8'hC0 | BYTE_W'($urandom_range(0, 31));
            3:       lead = 8'hE0 | BYTE_W'($urandom_range(0, 15));
            default: lead = 8'hF0 | BYTE_W'($urandom_range(0, 7));
        endcase
        q.push_back(lead);
        repeat (nbytes - 1) q.push_back(CONT_TAG | BYTE_W'($urandom_range(0, 63)));
    endfunction

    task automatic run_mixed(input int items);
        int                sent;
        int                kind;
        int                clen;
        int                ridx;
        logic [BYTE_W-1:0] str[$];
        sent = 0;
        while (sent < items)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 45) begin
                str.delete();
                repeat ($urandom_range(1, 4)) append_codepoint($urandom_range(1, 4), str);
                // mostly exact, sometimes short (cut) or long (budget left open)
                case ($urandom_range(0, 7))
                    0:       clen = str.size() - 1;
                    1:       clen = str.size() + $urandom_range(1, 3);
                    default: clen = str.size();
                endcase
                send_commit(str, clen);
                sent += str.size();
            end
            else if (kind < 80) begin
                case ($urandom_range(0, 2))
                    0:       send_edit(OP_DELETE);
                    1:       send_edit(OP_LEFT);
                    default: send_edit(OP_RIGHT);
                endcase
                sent++;
            end
            else if (kind < 92) begin
                ridx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, CAPACITY - 1)
                                                   : $urandom_range(0, 40);
                send_word(OP_READ, BYTE_W'($urandom), 1'($urandom), LEN_W'($urandom),
                          IDX_W'(ridx));
                sent++;
            end
            else if (kind < 93) begin
                send_edit(OP_CLEAR);
                sent++;
            end
            else
            begin
                send_word(OP_W'($urandom_range(0, 7)), BYTE_W'($urandom), 1'($urandom),
                          LEN_W'($urandom), IDX_W'($urandom));
                sent++;
            end
        end
    endtask

    initial
    begin
        logic [BYTE_W-1:0] str[$];
        rst_n                <= 1'b0;
        cmd_if.valid         <= 1'b0;
        cmd_if.op            <= OP_READ;
        cmd_if.data_byte     <= '0;
        cmd_if.commit_first  <= 1'b0;
        cmd_if.commit_length <= '0;
        cmd_if.read_index    <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // edges of an empty buffer and the unused codes
        send_edit(OP_DELETE);
        send_edit(OP_LEFT);
        send_edit(OP_RIGHT);
        send_word(OP_READ, 8'h00, 1'b0, 12'h000, 11'h000);
        send_word(OP_SPARE_A, 8'h00, 1'b0, 12'h000, 11'h000);
        send_word(OP_SPARE_B, 8'hFF, 1'b1, 12'hFFF, 11'h7FF);

        // byte outside a commit, then an empty commit
        send_insert(8'h41, 1'b0, 7);
        send_insert(8'h42, 1'b1, 0);

        str = {8'hC3, 8'hA9};
        send_commit(str, 2);
        str = {8'hE2, 8'h82, 8'hAC};
        send_commit(str, 3);
        str = {8'hF0, 8'h9F, 8'h98, 8'h80};
        send_commit(str, 4);
        send_edit(OP_LEFT);
        send_edit(OP_LEFT);
        send_edit(OP_RIGHT);
        send_edit(OP_DELETE);
        send_word(OP_READ, 8'h00, 1'b0, 12'h000, 11'd2);
        send_edit(OP_RIGHT);
        send_edit(OP_RIGHT);

        // new commit replaces an unfinished one
        send_insert(8'h00, 1'b1, 5);
        send_insert(8'hFF, 1'b1, 1);
        send_insert(8'h7F, 1'b0, 1);

        // clear inside a commit drops the rest
        send_insert(8'h80, 1'b1, 3);
        send_edit(OP_CLEAR);
        send_insert(8'hBF, 1'b0, 3);

        // stray continuation bytes and the longest commit length
        send_insert(8'h80, 1'b1, 4095);
        send_insert(8'hBF, 1'b0, 0);
        send_edit(OP_LEFT);
        send_word(OP_READ, 8'h00, 1'b0, 12'h000, 11'h7FF);

        run_mixed(120);

        // commits with long declared lengths, after moving the cursor left
        repeat (6)
        begin
            repeat ($urandom_range(0, 4)) send_edit(OP_LEFT);
            str.delete();
            repeat ($urandom_range(1, 3)) append_codepoint($urandom_range(1, 4), str);
            send_commit(str, $urandom_range(CAPACITY / 2 + 64, 4095));
        end

        run_mixed(90);

        cmd_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (2 * CAPACITY) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== utf8_cursor_text_buffer.f =====
rtl/uctb_pkg.sv
rtl/uctb_in_if.sv
rtl/uctb_out_if.sv
rtl/utf8_cursor_text_buffer.sv
tb/utf8_edit_checker.sv
tb/tb_utf8_cursor_text_buffer.sv
